// ----- rtl/core/slx_pkg.sv -----
// Shared types, keyword table and constants for the SQL lexer stream unit.
`default_nettype none

package slx_pkg;

  localparam int unsigned KW_MAX       = 12;
  localparam int unsigned KW_COUNT_DEF = 12;
  localparam int unsigned Q_DEPTH      = 4;
  localparam int unsigned MAX_RES      = 3;

  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_STRING  = 3'd3,
    KIND_OPER    = 3'd4,
    KIND_PUNCT   = 3'd5,
    KIND_UNKNOWN = 3'd6
  } kind_e;

  // Keyword text, upper case, zero padded to eight characters.
  localparam logic [7:0] KW_TEXT [KW_MAX][8] = '{
    '{"S", "E", "L", "E", "C", "T", 8'h00, 8'h00},
    '{"F", "R", "O", "M", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"W", "H", "E", "R", "E", 8'h00, 8'h00, 8'h00},
    '{"I", "N", "S", "E", "R", "T", 8'h00, 8'h00},
    '{"I", "N", "T", "O", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"V", "A", "L", "U", "E", "S", 8'h00, 8'h00},
    '{"U", "P", "D", "A", "T", "E", 8'h00, 8'h00},
    '{"S", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
    '{"C", "R", "E", "A", "T", "E", 8'h00, 8'h00},
    '{"T", "A", "B", "L", "E", 8'h00, 8'h00, 8'h00},
    '{"D", "R", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] KW_LEN [KW_MAX] = '{
    3'd6, 3'd4, 3'd5, 3'd6, 3'd4, 3'd6, 3'd6, 3'd3, 3'd6, 3'd6, 3'd5, 3'd4
  };

  // One result word.
  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    kind_e      kind;
    logic       tok_end;
    logic [3:0] kw_idx;
    logic [7:0] len;
    logic       len_ovf;
    logic       last;
  } rec_t;

  // All results caused by one input word, in order.
  typedef struct packed {
    logic [1:0]               n;
    rec_t [MAX_RES-1:0]       rec;
  } bundle_t;

endpackage

`default_nettype wire

// ----- rtl/core/slx_front.sv -----
// Front end: lexer state, character classification and keyword mask.
`default_nettype none

module slx_front #(
  parameter int unsigned KeywordCount = slx_pkg::KW_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       in_char_i,
  input  logic             end_of_input_i,
  input  logic             accept_i,
  output slx_pkg::bundle_t bundle_o
);
  import slx_pkg::*;

  localparam int unsigned KwActive = (KeywordCount < KW_MAX) ? KeywordCount : KW_MAX;
  localparam logic [KW_MAX-1:0] InitMask = KW_MAX'((64'd1 << KwActive) - 64'd1);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_STR  = 2'd3
  } mode_e;

  mode_e             mode_q, mode_d;
  logic [KW_MAX-1:0] cand_q, cand_d;
  logic [7:0]        cnt_q, cnt_d;
  logic              ovf_q, ovf_d;

  // Close result for a token in the given state.
  function automatic rec_t close_rec(mode_e m, logic [KW_MAX-1:0] cand,
                                     logic [7:0] cnt, logic ovf);
    rec_t r;
    r = '0;
    r.tok_end = 1'b1;
    r.len     = cnt;
    r.len_ovf = ovf;
    case (m)
      MODE_NUM: r.kind = KIND_NUMBER;
      MODE_STR: r.kind = KIND_STRING;
      default: begin
        r.kind = KIND_IDENT;
        if (!ovf) begin
          for (int k = KW_MAX - 1; k >= 0; k--) begin
            if (cand[k] && ({5'd0, KW_LEN[k]} == cnt)) begin
              r.kind   = KIND_KEYWORD;
              r.kw_idx = 4'(k);
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  logic [7:0]        c, up;
  logic              is_space, is_alpha, is_digit, is_quote, is_word;
  logic              cont, pre;
  mode_e             amode;
  logic [KW_MAX-1:0] acand, fcand;
  logic [7:0]        acnt, fcnt;
  logic              aovf, fovf, post;
  rec_t              pre_rec, mid_rec, post_rec;
  rec_t [MAX_RES-1:0] slots;
  logic [1:0]        n;

  assign c = in_char_i;

  always_comb begin
    up       = (c inside {[8'h61:8'h7a]}) ? (c - 8'd32) : c;
    is_space = (c inside {8'h20, [8'h09:8'h0d]});
    is_alpha = (c inside {[8'h41:8'h5a], [8'h61:8'h7a]});
    is_digit = (c inside {[8'h30:8'h39]});
    is_quote = (c == 8'h27);
    is_word  = is_alpha || is_digit || (c == 8'h5f);

    cont = ((mode_q == MODE_WORD) && is_word) || ((mode_q == MODE_NUM) && is_digit) ||
           (mode_q == MODE_STR);
    pre  = ((mode_q == MODE_WORD) || (mode_q == MODE_NUM)) && !cont;

    // State the character advances: the running token, or a fresh one.
    if (cont) begin
      amode = mode_q;
      acand = cand_q;
      acnt  = cnt_q;
      aovf  = ovf_q;
    end else begin
      if (is_alpha)      amode = MODE_WORD;
      else if (is_digit) amode = MODE_NUM;
      else if (is_quote) amode = MODE_STR;
      else               amode = MODE_IDLE;
      acand = (amode == MODE_WORD) ? InitMask : '0;
      acnt  = '0;
      aovf  = 1'b0;
    end

    // Narrow the keyword mask at position acnt.
    fcand = acand;
    if (amode == MODE_WORD) begin
      for (int k = 0; k < KW_MAX; k++) begin
        if (!(acnt < {5'd0, KW_LEN[k]}) || (KW_TEXT[k][acnt[2:0]] != up)) begin
          fcand[k] = 1'b0;
        end
      end
    end
    if (acnt == 8'hff) begin
      fcnt = acnt;
      fovf = 1'b1;
    end else begin
      fcnt = acnt + 8'd1;
      fovf = aovf;
    end

    post = (amode != MODE_IDLE) &&
           (((amode == MODE_STR) && cont && is_quote) || end_of_input_i);

    pre_rec  = close_rec(mode_q, cand_q, cnt_q, ovf_q);
    post_rec = close_rec(amode, fcand, fcnt, fovf);

    mid_rec          = '0;
    mid_rec.ch       = c;
    mid_rec.ch_valid = 1'b1;
    case (amode)
      MODE_WORD: mid_rec.kind = KIND_IDENT;
      MODE_NUM:  mid_rec.kind = KIND_NUMBER;
      MODE_STR:  mid_rec.kind = KIND_STRING;
      default: begin
        mid_rec.tok_end = 1'b1;
        mid_rec.len     = 8'd1;
        if (c inside {8'h3d, 8'h3e, 8'h3c, 8'h21, 8'h2b, 8'h2d, 8'h2a, 8'h2f}) begin
          mid_rec.kind = KIND_OPER;
        end else if (c inside {8'h2c, 8'h3b, 8'h28, 8'h29}) begin
          mid_rec.kind = KIND_PUNCT;
        end else begin
          mid_rec.kind = KIND_UNKNOWN;
        end
      end
    endcase

    // Pack results in order: prior close, echo or single, trailing close.
    slots = '0;
    n     = 2'd0;
    if (pre) begin
      slots[n] = pre_rec;
      n        = n + 2'd1;
    end
    if ((amode != MODE_IDLE) || !is_space) begin
      slots[n] = mid_rec;
      n        = n + 2'd1;
    end
    if (post) begin
      slots[n] = post_rec;
      n        = n + 2'd1;
    end
    if (n != 2'd0) begin
      slots[n - 2'd1].last = 1'b1;
    end

    if (post || (amode == MODE_IDLE)) begin
      mode_d = MODE_IDLE;
      cand_d = '0;
      cnt_d  = '0;
      ovf_d  = 1'b0;
    end else begin
      mode_d = amode;
      cand_d = fcand;
      cnt_d  = fcnt;
      ovf_d  = fovf;
    end
  end

  assign bundle_o.n   = n;
  assign bundle_o.rec = slots;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cand_q <= '0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cand_q <= cand_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/slx_queue.sv -----
// Small queue of result bundles between front end and back end.
`default_nettype none

module slx_queue #(
  parameter int unsigned Depth = slx_pkg::Q_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  slx_pkg::bundle_t wdata_i,
  input  logic             pop_i,
  output slx_pkg::bundle_t rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  import slx_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  bundle_t         mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;

  function automatic logic [AW-1:0] nxt(logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : (p + AW'(1));
  endfunction

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i)  rd_q <= nxt(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/slx_back.sv -----
// Back end: walks each bundle one result at a time into the output register.
`default_nettype none

module slx_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  slx_pkg::bundle_t head_i,
  input  logic             head_valid_i,
  output logic             head_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output slx_pkg::rec_t    rec_o
);
  import slx_pkg::*;

  logic [1:0] sel_q;
  logic       out_valid_q;
  rec_t       out_q;
  logic       load, at_end;

  assign load       = head_valid_i && (!out_valid_q || pop_i);
  assign at_end     = (sel_q == (head_i.n - 2'd1));
  assign head_pop_o = load && at_end;
  assign empty_o    = !out_valid_q;
  assign rec_o      = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= head_i.rec[sel_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        sel_q       <= at_end ? 2'd0 : (sel_q + 2'd1);
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sql_lexer_stream_unit.sv -----
// Streaming SQL lexer: top level joining front end, bundle queue and back end.
// Path: an accepted character's results are written as one bundle into the queue, and the
//   back end then moves the first of them into the registered output, where it can be popped.
// Throughput: one character per cycle; results leave at one per cycle while pop is held,
//   so a character with two or three results holds input back once the bundle queue fills.
// Reset (rst_ni low, asynchronous): lexer idle, keyword mask and counts cleared,
//   queue and output register emptied.
`default_nettype none

module sql_lexer_stream_unit #(
  parameter int unsigned KeywordCount = slx_pkg::KW_COUNT_DEF,
  parameter int unsigned QueueDepth   = slx_pkg::Q_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input word
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char_i,
  input  logic       end_of_input_i,
  // result word
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       char_valid_o,
  output logic [2:0] token_kind_o,
  output logic       token_end_o,
  output logic [3:0] keyword_index_o,
  output logic [7:0] token_length_o,
  output logic       length_overflow_o,
  output logic       last_result_o
);
  import slx_pkg::*;

  logic    accept;
  bundle_t bundle, head;
  logic    q_push, q_pop, q_full, q_empty;
  rec_t    rec;

  // A word is taken whenever the queue has room; whitespace words outside
  // a token push nothing.
  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept && (bundle.n != 2'd0);

  // Front end: classifies the character and builds every result it causes.
  slx_front #(
    .KeywordCount(KeywordCount)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_char_i     (in_char_i),
    .end_of_input_i(end_of_input_i),
    .accept_i      (accept),
    .bundle_o      (bundle)
  );

  // Decouples the two sides so each can stall on its own.
  slx_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(bundle),
    .pop_i  (q_pop),
    .rdata_o(head),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  // Back end: one result per cycle into a registered output while the receiver pops.
  slx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .head_valid_i(!q_empty),
    .head_pop_o  (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .rec_o       (rec)
  );

  assign out_char_o        = rec.ch;
  assign char_valid_o      = rec.ch_valid;
  assign token_kind_o      = rec.kind;
  assign token_end_o       = rec.tok_end;
  assign keyword_index_o   = rec.kw_idx;
  assign token_length_o    = rec.len;
  assign length_overflow_o = rec.len_ovf;
  assign last_result_o     = rec.last;

  // Queue is never written while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("bundle pushed into full queue");

  // Back end only retires a bundle that is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("bundle popped from empty queue");

  // A retired bundle ends on the result marked last.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |=> rec.last)
    else $error("bundle retired without its last result");

  // Every pushed bundle holds one to three results, the final one marked last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (bundle.n != 2'd0) && bundle.rec[bundle.n - 2'd1].last)
    else $error("malformed bundle");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the streaming SQL lexer: scoreboard, drivers, watchdog.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slx_pkg::*;

  localparam int unsigned KW_NUM      = 12;
  localparam byte unsigned QUOTE      = 8'h27;
  localparam int unsigned HOLD_CYCLES = 80;    // long receiver hold-off
  localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no word moving
  localparam int unsigned DRAIN_WAIT  = 8;     // margin for a stray word after the drain

  // Token scoreboard: tracks the lexer state, predicts result words and
  // checks the DUT output against the oldest prediction.
  class token_scoreboard;
    typedef enum logic [1:0] {
      LX_IDLE   = 2'd0,
      LX_WORD   = 2'd1,
      LX_NUMBER = 2'd2,
      LX_STRING = 2'd3
    } lex_state_e;

    lex_state_e  lex_state = LX_IDLE;
    logic [11:0] kw_cand   = '0;
    byte unsigned tok_len  = 0;
    bit          tok_ovf   = 1'b0;

    rec_t batch[$];
    rec_t pending_results[$];

    int unsigned mismatches      = 0;
    int unsigned results_checked = 0;
    int unsigned keyword_closes  = 0;
    int unsigned overflow_closes = 0;

    static function string keyword_text(int k);
      case (k)
        0:  return "SELECT";
        1:  return "FROM";
        2:  return "WHERE";
        3:  return "INSERT";
        4:  return "INTO";
        5:  return "VALUES";
        6:  return "UPDATE";
        7:  return "SET";
        8:  return "DELETE";
        9:  return "CREATE";
        10: return "TABLE";
        default: return "DROP";
      endcase
    endfunction

    function bit is_space(byte unsigned c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function bit is_alpha(byte unsigned c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_digit(byte unsigned c);
      return c >= "0" && c <= "9";
    endfunction

    function void emit(byte unsigned ch, bit valid, kind_e kind, bit done,
                       logic [3:0] idx, byte unsigned len, bit ovf);
      rec_t r;
      r.ch       = ch;
      r.ch_valid = valid;
      r.kind     = kind;
      r.tok_end  = done;
      r.kw_idx   = idx;
      r.len      = len;
      r.len_ovf  = ovf;
      r.last     = 1'b0;
      batch.push_back(r);
    endfunction

    // One more character in the token: narrow the keyword mask, bump the length.
    function void advance(byte unsigned c);
      byte unsigned up;
      string kw;
      up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
      if (lex_state == LX_WORD) begin
        for (int k = 0; k < KW_NUM; k++) begin
          kw = keyword_text(k);
          if (kw_cand[k] && (tok_len >= kw.len() || byte'(kw[tok_len]) != up)) begin
            kw_cand[k] = 1'b0;
          end
        end
      end
      if (tok_len == 8'd255) begin
        tok_ovf = 1'b1;
      end else begin
        tok_len++;
      end
    endfunction

    function void start_token(lex_state_e mode, byte unsigned c);
      lex_state = mode;
      tok_len   = 0;
      tok_ovf   = 1'b0;
      kw_cand   = (mode == LX_WORD) ? '1 : '0;
      advance(c);
    endfunction

    function void close_token();
      kind_e kind;
      logic [3:0] idx;
      string kw;
      kind = KIND_IDENT;
      idx  = '0;
      if (lex_state == LX_NUMBER) begin
        kind = KIND_NUMBER;
      end else if (lex_state == LX_STRING) begin
        kind = KIND_STRING;
      end else if (!tok_ovf) begin
        for (int k = 0; k < KW_NUM; k++) begin
          kw = keyword_text(k);
          if (kw_cand[k] && kw.len() == tok_len) begin
            kind = KIND_KEYWORD;
            idx  = 4'(k);
            break;
          end
        end
      end
      emit(8'h00, 1'b0, kind, 1'b1, idx, tok_len, tok_ovf);
      lex_state = LX_IDLE;
      kw_cand   = '0;
      tok_len   = 0;
      tok_ovf   = 1'b0;
    endfunction

    function void from_idle(byte unsigned c);
      kind_e kind;
      if (is_space(c)) return;
      if (is_alpha(c)) begin
        start_token(LX_WORD, c);
        emit(c, 1'b1, KIND_IDENT, 1'b0, '0, 8'd0, 1'b0);
        return;
      end
      if (is_digit(c)) begin
        start_token(LX_NUMBER, c);
        emit(c, 1'b1, KIND_NUMBER, 1'b0, '0, 8'd0, 1'b0);
        return;
      end
      if (c == QUOTE) begin
        start_token(LX_STRING, c);
        emit(c, 1'b1, KIND_STRING, 1'b0, '0, 8'd0, 1'b0);
        return;
      end
      if (c == "=" || c == ">" || c == "<" || c == "!" || c == "+" || c == "-" ||
          c == "*" || c == "/") begin
        kind = KIND_OPER;
      end else if (c == "," || c == ";" || c == "(" || c == ")") begin
        kind = KIND_PUNCT;
      end else begin
        kind = KIND_UNKNOWN;
      end
      emit(c, 1'b1, kind, 1'b1, '0, 8'd1, 1'b0);
    endfunction

    // Accepted input word: queue every result word it causes.
    function void lex_char(byte unsigned c, bit eoi);
      bit handled;
      handled = 1'b0;
      batch.delete();
      case (lex_state)
        LX_WORD: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            advance(c);
            emit(c, 1'b1, KIND_IDENT, 1'b0, '0, 8'd0, 1'b0);
            handled = 1'b1;
          end else begin
            close_token();
          end
        end
        LX_NUMBER: begin
          if (is_digit(c)) begin
            advance(c);
            emit(c, 1'b1, KIND_NUMBER, 1'b0, '0, 8'd0, 1'b0);
            handled = 1'b1;
          end else begin
            close_token();
          end
        end
        LX_STRING: begin
          advance(c);
          emit(c, 1'b1, KIND_STRING, 1'b0, '0, 8'd0, 1'b0);
          if (c == QUOTE) close_token();
          handled = 1'b1;
        end
        default: ;
      endcase
      if (!handled) from_idle(c);
      if (eoi && lex_state != LX_IDLE) close_token();
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending_results.push_back(batch[i]);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(rec_t got);
      rec_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual char 0x%0h kind %0d",
                 $time, got.ch, got.kind);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (want.tok_end && want.kind == KIND_KEYWORD) keyword_closes++;
      if (want.len_ovf) overflow_closes++;
      compare_field("out_char",        want.ch,       got.ch);
      compare_field("char_valid",      want.ch_valid, got.ch_valid);
      compare_field("token_kind",      want.kind,     got.kind);
      compare_field("token_end",       want.tok_end,  got.tok_end);
      compare_field("keyword_index",   want.kw_idx,   got.kw_idx);
      compare_field("token_length",    want.len,      got.len);
      compare_field("length_overflow", want.len_ovf,  got.len_ovf);
      compare_field("last_result",     want.last,     got.last);
    endfunction
  endclass

  // Clock, reset and DUT pins; all inputs known from time zero.
  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       push           = 1'b0;
  logic       full;
  logic [7:0] in_char_i      = 8'h00;
  logic       end_of_input_i = 1'b0;
  logic       empty;
  logic       pop            = 1'b0;
  logic [7:0] out_char_o;
  logic       char_valid_o;
  logic [2:0] token_kind_o;
  logic       token_end_o;
  logic [3:0] keyword_index_o;
  logic [7:0] token_length_o;
  logic       length_overflow_o;
  logic       last_result_o;

  token_scoreboard sb;

  // Sender pacing
  int unsigned burst_left = 0;
  bit          no_gaps    = 1'b0;
  int unsigned items_sent = 0;
  // Receiver hold-off requests; the receiver counts the stretch itself
  int unsigned hold_asks  = 0;

  sql_lexer_stream_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .in_char_i        (in_char_i),
    .end_of_input_i   (end_of_input_i),
    .empty            (empty),
    .pop              (pop),
    .out_char_o       (out_char_o),
    .char_valid_o     (char_valid_o),
    .token_kind_o     (token_kind_o),
    .token_end_o      (token_end_o),
    .keyword_index_o  (keyword_index_o),
    .token_length_o   (token_length_o),
    .length_overflow_o(length_overflow_o),
    .last_result_o    (last_result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Input side. Drive at the falling edge, hold until a rising edge sees
  // push high with full low, then hand the word to the predictor.
  // Bursts of random length; gaps between them unless no_gaps is set.
  // ---------------------------------------------------------------------------
  task automatic send_char(input byte unsigned c, input bit eoi);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = no_gaps ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk_i);
        push <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    push           <= 1'b1;
    in_char_i      <= c;
    end_of_input_i <= eoi;
    do @(posedge clk_i); while (full);
    sb.lex_char(c, eoi);
    items_sent++;
  endtask

  task automatic send_text(input string s, input bit eoi_last);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], eoi_last && i == s.len() - 1);
    end
  endtask

  function automatic byte unsigned random_letter();
    int unsigned r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic byte unsigned word_char();
    int unsigned r;
    r = $urandom_range(0, 11);
    if (r < 8) return random_letter();
    if (r < 11) return 8'("0" + $urandom_range(0, 9));
    return "_";
  endfunction

  function automatic byte unsigned any_but_quote();
    byte unsigned c;
    do c = 8'($urandom_range(0, 255)); while (c == QUOTE);
    return c;
  endfunction

  // One random token, mostly well formed; end of input lands anywhere.
  task automatic send_random_token();
    byte unsigned tok[$];
    int unsigned pick, n;
    string kw, ops, punct;
    ops   = "=<>!+-*/";
    punct = ",;()";
    pick  = $urandom_range(0, 99);
    if (pick < 25) begin
      // keyword in mixed case; sometimes cut short or stretched into an identifier
      kw = token_scoreboard::keyword_text($urandom_range(0, KW_NUM - 1));
      for (int i = 0; i < kw.len(); i++) begin
        tok.push_back($urandom_range(0, 1) ? (kw[i] ^ 8'h20) : kw[i]);
      end
      n = $urandom_range(0, 5);
      if (n == 0) void'(tok.pop_back());
      if (n == 1) tok.push_back(word_char());
    end else if (pick < 40) begin
      tok.push_back(random_letter());
      repeat ($urandom_range(0, 7)) tok.push_back(word_char());
    end else if (pick < 52) begin
      repeat ($urandom_range(1, 6)) tok.push_back(8'("0" + $urandom_range(0, 9)));
    end else if (pick < 62) begin
      tok.push_back(QUOTE);
      repeat ($urandom_range(0, 6)) tok.push_back(any_but_quote());
      if ($urandom_range(0, 5) != 0) tok.push_back(QUOTE);
    end else if (pick < 72) begin
      tok.push_back(ops[$urandom_range(0, 7)]);
    end else if (pick < 80) begin
      tok.push_back(punct[$urandom_range(0, 3)]);
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 3)) begin
        tok.push_back($urandom_range(0, 1) ? 8'(" ") : 8'($urandom_range(9, 13)));
      end
    end else begin
      tok.push_back(8'($urandom_range(0, 255)));
    end
    foreach (tok[i]) send_char(tok[i], $urandom_range(0, 19) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side. pop changes at the falling edge: a random readiness level
  // that is redrawn at random, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : result_pacing
    int unsigned hold_left, hold_done, mode_left, ready_pct;
    hold_left = 0;
    hold_done = 0;
    mode_left = 0;
    ready_pct = 100;
    forever begin
      @(negedge clk_i);
      if (hold_done < hold_asks) begin
        hold_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(16, 64);
          case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 70;
            2: ready_pct = 40;
            default: ready_pct = 15;
          endcase
        end
        mode_left--;
        pop <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  // Accepted result word goes straight to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      sb.check_result(rec_t'{out_char_o, char_valid_o, kind_e'(token_kind_o), token_end_o,
                             keyword_index_o, token_length_o, length_overflow_o,
                             last_result_o});
    end
  end

  // Watchdog: too many cycles with no word moving on either side.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog expired, %0d cycles without progress", $time, QUIET_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned first_item;
    sb = new;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every token kind, the close-then-restart cases, end of input.
    send_text("DroP;", 1'b0);      // mixed-case keyword closed by punctuation
    send_text("x_9=", 1'b0);       // identifier with digit/underscore, operator closes
    send_text("42'x'", 1'b0);      // number closed by a quote; quote ends the string
    send_text("a", 1'b0);
    send_char(QUOTE, 1'b1);        // word close, string open, string closed by end: 3 words
    send_char(8'hFF, 1'b0);        // above 127: unknown
    send_char(8'h00, 1'b0);        // NUL: unknown
    send_char(8'h80, 1'b0);
    send_char(8'h09, 1'b1);        // whitespace at end of input while idle: nothing
    send_text("SeT", 1'b1);        // shortest keyword, closed by end of input
    send_text("7", 1'b1);

    // Receiver backs off for a long stretch while the sender keeps pushing.
    hold_asks++;
    no_gaps    = 1'b1;
    first_item = items_sent;
    while (items_sent - first_item < 25) send_random_token();

    // Main random run; one stretch without sender gaps.
    first_item = items_sent;
    while (items_sent - first_item < 45) begin
      no_gaps = (items_sent - first_item >= 20) && (items_sent - first_item < 30);
      send_random_token();
    end
    no_gaps = 1'b0;

    @(negedge clk_i);
    push <= 1'b0;

    // Drain, then wait out the DRAIN_WAIT margin so any stray word can show.
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Covered %0d input words, %0d result words, %0d keyword closes, %0d overflows.",
             items_sent, sb.results_checked, sb.keyword_closes, sb.overflow_closes);
    $display("Included a %0d-cycle receiver hold-off with the input side stalled.",
             HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/slx_pkg.sv
rtl/core/slx_front.sv
rtl/core/slx_queue.sv
rtl/core/slx_back.sv
rtl/core/sql_lexer_stream_unit.sv
tb/testbench.sv
